// ===== src/htb_pkg.sv =====
// Shared constants, types and helper functions for the height texture blend unit.
`timescale 1ns / 1ps

package htb_pkg;

  localparam int TEX_COUNT    = 5;
  localparam int THR_COUNT    = 8;
  localparam int THR_W        = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int TEXEL_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int CHAN_COUNT   = 3;
  localparam int FRAC_W       = 16;
  localparam int DIV_STAGES   = 4;
  localparam int DIV_BITS     = FRAC_W / DIV_STAGES;
  localparam int PIPE_DEPTH   = 8;

  // Pipeline stage positions
  localparam int ST_HEIGHT    = 0;
  localparam int ST_BAND      = 1;
  localparam int ST_DIV_FIRST = 2;
  localparam int ST_MUL       = ST_DIV_FIRST + DIV_STAGES;
  localparam int ST_OUT       = ST_MUL + 1;

  typedef logic [THR_W-1:0]   thr_t;
  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [FRAC_W-1:0]  frac_t;

  typedef struct packed {
    logic [THR_W-1:0]  rem;
    logic [FRAC_W-1:0] quot;
  } div_t;

  localparam thr_t THR_RESET [THR_COUNT] = '{
    8'd20, 8'd50, 8'd80, 8'd110, 8'd140, 8'd170, 8'd200, 8'd230
  };

  // Restoring division, DIV_BITS quotient bits per call. The remainder
  // always stays below span, so the shifted remainder fits in THR_W+1 bits.
  function automatic div_t div_step(input div_t d, input thr_t span);
    div_t            r;
    logic [THR_W:0]  r2;
    r = d;
    for (int b = 0; b < DIV_BITS; b++) begin
      r2 = {r.rem, 1'b0};
      if (r2 >= {1'b0, span}) begin
        r.rem  = THR_W'(r2 - {1'b0, span});
        r.quot = {r.quot[FRAC_W-2:0], 1'b1};
      end else begin
        r.rem  = r2[THR_W-1:0];
        r.quot = {r.quot[FRAC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== src/height_texture_blend_unit.sv =====
// Height based texture splatting: one pixel per clock, unless the output stalls, through an eight stage pipeline.
`timescale 1ns / 1ps

// Takes one pixel item per clock while rgb_stall is low (height, jitter, five RGB
// texels) and returns one blended RGB item per accepted pixel. The pipeline has one
// stage for the saturated height, one for the band search, four stages of the
// restoring divider that yields the 16-bit ramp fraction (four quotient bits
// each), one for the weight multipliers and one for the channel sum. Each stage
// holds its item until the next one has room, so a stalled output fills the
// pipeline before pix_stall rises. Thresholds are to be written by the user through
// cfg_we / cfg_index / cfg_data only while the pipeline is empty; the block does
// not enforce this. Indices above 7 are ignored.
module height_texture_blend_unit
  import htb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  // pixel input
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [7:0]           height,
  input  logic signed [4:0]    jitter,
  input  logic [TEXEL_W-1:0]   tex0,
  input  logic [TEXEL_W-1:0]   tex1,
  input  logic [TEXEL_W-1:0]   tex2,
  input  logic [TEXEL_W-1:0]   tex3,
  input  logic [TEXEL_W-1:0]   tex4,
  // blended output
  output logic                 rgb_valid,
  input  logic                 rgb_stall,
  output logic [CHAN_W-1:0]    red,
  output logic [CHAN_W-1:0]    green,
  output logic [CHAN_W-1:0]    blue
);

  // Threshold registers
  thr_t thr [THR_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(THR_COUNT))) begin
      thr[cfg_index[$clog2(THR_COUNT)-1:0]] <= cfg_data;
    end
  end

  // Stage valid bits and ready chain
  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH-1:0] rdy;

  always_comb begin
    rdy[PIPE_DEPTH-1] = !v[PIPE_DEPTH-1] || !rgb_stall;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign pix_stall = !rdy[ST_HEIGHT];
  assign rgb_valid = v[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[ST_HEIGHT]) begin
        v[ST_HEIGHT] <= pix_valid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 1: height plus jitter, saturated to 0..255
  logic signed [9:0] h_sum;
  thr_t              h_sat;
  thr_t              h1;
  texel_t            tx1 [TEX_COUNT];

  always_comb begin
    h_sum = $signed({2'b00, height}) + 10'(jitter);
    if (h_sum[9]) begin
      h_sat = '0;
    end else if (h_sum[8]) begin
      h_sat = '1;
    end else begin
      h_sat = h_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_HEIGHT]) begin
      h1     <= h_sat;
      tx1[0] <= tex0;
      tx1[1] <= tex1;
      tx1[2] <= tex2;
      tx1[3] <= tex3;
      tx1[4] <= tex4;
    end
  end

  // Stage 2: band search and selection of the two texels and ramp operands.
  // Flat bands use diff 0 over span 1, so the fraction comes out as zero.
  logic [3:0] band;
  thr_t       diff_b;
  thr_t       span_b;
  texel_t     tl_b;
  texel_t     tu_b;

  always_comb begin
    band = 4'(THR_COUNT);
    for (int i = THR_COUNT - 1; i >= 0; i--) begin
      if (h1 < thr[i]) begin
        band = 4'(i);
      end
    end
    diff_b = '0;
    span_b = THR_W'(1);
    tl_b   = tx1[0];
    tu_b   = tx1[0];
    for (int i = 0; i < TEX_COUNT; i++) begin
      if (band == 4'(2 * i)) begin
        tl_b = tx1[i];
      end
    end
    for (int i = 0; i < TEX_COUNT - 1; i++) begin
      if (band == 4'(2 * i + 1)) begin
        diff_b = h1 - thr[2*i];
        span_b = thr[2*i+1] - thr[2*i];
        tl_b   = tx1[i];
        tu_b   = tx1[i+1];
      end
    end
  end

  div_t   dv   [DIV_STAGES+1];
  thr_t   span [DIV_STAGES+1];
  texel_t tl   [DIV_STAGES+1];
  texel_t tu   [DIV_STAGES+1];

  // Stage 2 register, then stages 3..6: divider, four quotient bits per stage
  always_ff @(posedge clk) begin
    if (rdy[ST_BAND]) begin
      dv[0]   <= '{rem: diff_b, quot: '0};
      span[0] <= span_b;
      tl[0]   <= tl_b;
      tu[0]   <= tu_b;
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[ST_DIV_FIRST+s]) begin
        dv[s+1]   <= div_step(dv[s], span[s]);
        span[s+1] <= span[s];
        tl[s+1]   <= tl[s];
        tu[s+1]   <= tu[s];
      end
    end
  end

  // Stage 7: weight times texel per channel, each term truncated
  logic [FRAC_W:0]          w_lo;
  frac_t                    w_hi;
  logic [FRAC_W+CHAN_W-1:0] prod_lo [CHAN_COUNT];
  logic [FRAC_W+CHAN_W-1:0] prod_hi [CHAN_COUNT];
  chan_t                    term_lo [CHAN_COUNT];
  chan_t                    term_hi [CHAN_COUNT];

  always_comb begin
    w_hi = dv[DIV_STAGES].quot;
    w_lo = {1'b1, {FRAC_W{1'b0}}} - {1'b0, w_hi};
    for (int c = 0; c < CHAN_COUNT; c++) begin
      prod_lo[c] = (FRAC_W+CHAN_W)'(w_lo
                   * tl[DIV_STAGES][TEXEL_W-1-CHAN_W*c -: CHAN_W]);
      prod_hi[c] = (FRAC_W+CHAN_W)'(w_hi
                   * tu[DIV_STAGES][TEXEL_W-1-CHAN_W*c -: CHAN_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_MUL]) begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
        term_lo[c] <= prod_lo[c][FRAC_W+CHAN_W-1:FRAC_W];
        term_hi[c] <= prod_hi[c][FRAC_W+CHAN_W-1:FRAC_W];
      end
    end
  end

  // Stage 8: channel sum, saturated, into the output register
  logic [CHAN_W:0] csum [CHAN_COUNT];
  chan_t           cres [CHAN_COUNT];

  always_comb begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      csum[c] = {1'b0, term_lo[c]} + {1'b0, term_hi[c]};
      cres[c] = csum[c][CHAN_W] ? '1 : csum[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      red   <= cres[0];
      green <= cres[1];
      blue  <= cres[2];
    end
  end

  // Input is held back only when the first stage is occupied
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> v[ST_HEIGHT])
    else $error("pixel input stalled with an empty first stage");

  // Divider remainder never reaches the span
  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    v[ST_MUL-1] |-> (dv[DIV_STAGES].rem < span[DIV_STAGES]))
    else $error("divider remainder out of range");

  // Flat bands must leave a zero fraction
  a_flat_zero_frac: assert property (@(posedge clk) disable iff (rst)
    (v[ST_MUL-1] && (span[DIV_STAGES] == THR_W'(1))) |-> (dv[DIV_STAGES].quot == '0))
    else $error("non-zero fraction in a flat band");

  // The two weighted terms can never overflow a channel
  a_terms_fit: assert property (@(posedge clk) disable iff (rst)
    v[ST_OUT-1] |-> (!csum[0][CHAN_W] && !csum[1][CHAN_W] && !csum[2][CHAN_W]))
    else $error("blended channel exceeds full scale");

endmodule

// ===== tb/height_texture_blend_unit_tb.sv =====
// Self-checking testbench for the height texture blend unit: threshold phases, pixel stream, scoreboard.
`timescale 1ns / 1ps

module height_texture_blend_unit_tb;
  import htb_pkg::*;

  localparam int unsigned WEIGHT_FULL = 1 << FRAC_W;
  localparam int unsigned CHAN_MAX    = (1 << CHAN_W) - 1;
  localparam int          STUCK_LIMIT = 4000;
  localparam int          PHASES      = 8;

  typedef struct packed {
    logic [7:0]                height;
    logic signed [4:0]         jitter;
    texel_t [TEX_COUNT-1:0]    tex;
  } pixel_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Threshold settings visited by the run
  typedef enum {
    THR_AS_RESET,
    THR_ASCENDING,
    THR_ALL_ZERO,
    THR_ALL_FULL,
    THR_WIDE_RAMP,
    THR_NARROW_RAMPS,
    THR_SCRAMBLED
  } thr_plan_t;

  // Scoreboard: mirrors the thresholds and predicts the blended colour per pixel
  class blend_scoreboard;
    thr_t        thr [THR_COUNT];
    rgb_t        pending_rgb [$];
    int unsigned errors;

    function new();
      foreach (thr[k]) thr[k] = THR_RESET[k];
      errors = 0;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, thr_t value);
      if (idx < THR_COUNT) thr[idx] = value;
    endfunction

    function int pending();
      return pending_rgb.size();
    endfunction

    function rgb_t blend(pixel_t p);
      int          lvl;
      int unsigned w [TEX_COUNT];
      int unsigned lo, span, frac, total;
      logic [CHAN_W-1:0] texel;
      chan_t       chan [CHAN_COUNT];
      bit          banded;
      rgb_t        r;
      // saturated height
      lvl = int'(p.height) + int'($signed(p.jitter));
      if (lvl < 0) lvl = 0;
      else if (lvl > 255) lvl = 255;
      // band search: even limits close a flat band, odd limits a ramp
      foreach (w[k]) w[k] = 0;
      banded = 1'b0;
      for (int k = 0; k < THR_COUNT; k++) begin
        if (!banded && lvl < int'(thr[k])) begin
          banded = 1'b1;
          if (k % 2 == 0) begin
            w[k/2] = WEIGHT_FULL;
          end else begin
            lo       = thr[k-1];
            span     = thr[k] - lo;
            frac     = ((lvl - lo) << FRAC_W) / span;
            w[k/2]   = WEIGHT_FULL - frac;
            w[k/2+1] = frac;
          end
        end
      end
      if (!banded) w[TEX_COUNT-1] = WEIGHT_FULL;
      // per channel: truncated terms, then saturate
      for (int c = 0; c < CHAN_COUNT; c++) begin
        total = 0;
        for (int k = 0; k < TEX_COUNT; k++) begin
          texel = p.tex[k][CHAN_W*(CHAN_COUNT-1-c) +: CHAN_W];
          total += (w[k] * texel) >> FRAC_W;
        end
        chan[c] = (total > CHAN_MAX) ? chan_t'(CHAN_MAX) : chan_t'(total);
      end
      r.red   = chan[0];
      r.green = chan[1];
      r.blue  = chan[2];
      return r;
    endfunction

    function void note_pixel(pixel_t p);
      pending_rgb.push_back(blend(p));
    endfunction

    function void compare_chan(string name, chan_t want, chan_t got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_rgb(chan_t red, chan_t green, chan_t blue);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        $error("unexpected item: red %0d green %0d blue %0d", red, green, blue);
        errors++;
        return;
      end
      want = pending_rgb.pop_front();
      compare_chan("red", want.red, red);
      compare_chan("green", want.green, green);
      compare_chan("blue", want.blue, blue);
    endfunction
  endclass

  // DUT signals
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [7:0]           height = '0;
  logic signed [4:0]    jitter = '0;
  texel_t               tex0 = '0;
  texel_t               tex1 = '0;
  texel_t               tex2 = '0;
  texel_t               tex3 = '0;
  texel_t               tex4 = '0;
  logic                 rgb_valid;
  logic                 rgb_stall = 1'b0;
  chan_t                red, green, blue;

  blend_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              stuck_cycles = 0;

  height_texture_blend_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .height    (height),
    .jitter    (jitter),
    .tex0      (tex0),
    .tex1      (tex1),
    .tex2      (tex2),
    .tex3      (tex3),
    .tex4      (tex4),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 27);
  endfunction

  // Random pixel: half the heights land close to a threshold
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     h;
    if ($urandom_range(1) == 0) begin
      h = int'($urandom_range(255));
    end else begin
      h = int'(sb.thr[$urandom_range(THR_COUNT-1)]) + int'($urandom_range(4)) - 2;
      if (h < 0) h = 0;
      else if (h > 255) h = 255;
    end
    p.height = 8'(h);
    p.jitter = 5'($urandom_range(31));
    for (int k = 0; k < TEX_COUNT; k++) begin
      case ($urandom_range(9))
        0:       p.tex[k] = '0;
        1:       p.tex[k] = '1;
        default: p.tex[k] = texel_t'($urandom());
      endcase
    end
    return p;
  endfunction

  function automatic void plan_thresholds(thr_plan_t plan, output thr_t t [THR_COUNT]);
    int base;
    case (plan)
      THR_AS_RESET:  foreach (t[k]) t[k] = THR_RESET[k];
      THR_ASCENDING: begin
        foreach (t[k]) t[k] = thr_t'($urandom_range(255));
        t.sort();
      end
      THR_ALL_ZERO:  foreach (t[k]) t[k] = '0;
      THR_ALL_FULL:  foreach (t[k]) t[k] = '1;
      THR_WIDE_RAMP: begin
        foreach (t[k]) t[k] = '1;
        t[0] = '0;
      end
      THR_NARROW_RAMPS: begin
        base = int'($urandom_range(255 - THR_COUNT));
        foreach (t[k]) t[k] = thr_t'(base + k);
      end
      default:       foreach (t[k]) t[k] = thr_t'($urandom_range(255));
    endcase
  endfunction

  // Pixel driver: optional idle cycles, then hold the item until it is taken
  task automatic send_pixel(pixel_t p);
    while (take_break()) begin
      @(negedge clk);
      pix_valid <= 1'b0;
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    height    <= p.height;
    jitter    <= p.jitter;
    tex0      <= p.tex[0];
    tex1      <= p.tex[1];
    tex2      <= p.tex[2];
    tex3      <= p.tex[3];
    tex4      <= p.tex[4];
    do @(posedge clk); while (pix_stall !== 1'b0);
    sb.note_pixel(p);
  endtask

  task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, thr_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_threshold(idx, value);
  endtask

  // Only called with the pipeline empty; a write to a spare index goes last
  task automatic load_thresholds(thr_t t [THR_COUNT]);
    for (int k = 0; k < THR_COUNT; k++) write_threshold(CFG_IDX_W'(k), t[k]);
    write_threshold(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, THR_COUNT)),
                    thr_t'($urandom_range(255)));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Directed pixels: saturation corners, texel extremes, every band edge
  task automatic run_directed();
    pixel_t p;
    p = random_pixel(); p.height = 8'd0;   p.jitter = -5'sd16; p.tex = '1; send_pixel(p);
    p = random_pixel(); p.height = 8'd255; p.jitter = 5'sd15;  p.tex = '1; send_pixel(p);
    p = random_pixel(); p.height = 8'd0;   p.jitter = 5'sd0;   p.tex = '0; send_pixel(p);
    p = random_pixel(); p.height = 8'd255; p.jitter = -5'sd16; send_pixel(p);
    p = random_pixel(); p.height = 8'd0;   p.jitter = 5'sd15;  send_pixel(p);
    p = random_pixel(); p.height = 8'd128; p.jitter = 5'sd0;   send_pixel(p);
    for (int k = 0; k < THR_COUNT; k++) begin
      p = random_pixel(); p.height = sb.thr[k];        p.jitter = 5'sd0; send_pixel(p);
      p = random_pixel(); p.height = sb.thr[k] - 8'd1; p.jitter = 5'sd0; send_pixel(p);
    end
    // jitter pulls the height back across a limit
    p = random_pixel(); p.height = sb.thr[1] + 8'd1; p.jitter = -5'sd3; send_pixel(p);
  endtask

  // Receiver stall
  always @(negedge clk) begin
    rgb_stall <= !quiet && ($urandom_range(99) < 27);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && rgb_valid === 1'b1 && rgb_stall === 1'b0) sb.check_rgb(red, green, blue);
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (pix_valid && pix_stall === 1'b0) || (rgb_valid === 1'b1 && !rgb_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[height_texture_blend_unit] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    thr_plan_t plan [PHASES];
    int        items [PHASES];
    thr_t      t [THR_COUNT];

    plan  = '{THR_AS_RESET, THR_ASCENDING, THR_ALL_ZERO, THR_ALL_FULL,
              THR_WIDE_RAMP, THR_NARROW_RAMPS, THR_SCRAMBLED, THR_ASCENDING};
    items = '{60, 120, 25, 25, 40, 60, 120, 200};

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (plan[ph] != THR_AS_RESET) begin
        @(negedge clk);
        pix_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        plan_thresholds(plan[ph], t);
        load_thresholds(t);
      end else begin
        run_directed();
      end
      for (int n = 0; n < items[ph]; n++) begin
        // last phase opens with a stretch where neither side idles
        quiet = (ph == PHASES - 1) && (n < 150);
        send_pixel(random_pixel());
      end
      quiet = 1'b0;
    end

    // drain
    @(negedge clk);
    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[height_texture_blend_unit] OK");
    end else begin
      $display("[height_texture_blend_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/htb_pkg.sv
src/height_texture_blend_unit.sv
tb/height_texture_blend_unit_tb.sv
